// ===== src/pse_pkg.sv =====
`default_nettype none

package pse_pkg;

    // parse phases
    localparam logic [2:0] PH_LENGTH = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_TYPE   = 3'd3;
    localparam logic [2:0] PH_PIDHI  = 3'd4;
    localparam logic [2:0] PH_PIDLO  = 3'd5;
    localparam logic [2:0] PH_INFOHI = 3'd6;
    localparam logic [2:0] PH_INFOLO = 3'd7;

    // shortest section that carries a full header and crc
    localparam logic [11:0] MIN_LENGTH = 12'd13;
    localparam logic [11:0] CRC_BYTES  = 12'd4;

    // program info length offsets, counted from byte 3
    localparam logic [11:0] OFF_INFO_HI = 12'd7;
    localparam logic [11:0] OFF_INFO_LO = 12'd8;

    // stream types of interest
    localparam logic [7:0] ST_VIDEO_A = 8'd1;
    localparam logic [7:0] ST_VIDEO_B = 8'd2;
    localparam logic [7:0] ST_AUDIO_A = 8'd3;
    localparam logic [7:0] ST_AUDIO_B = 8'd4;
    localparam logic [7:0] ST_TTX     = 8'd6;

    typedef struct packed {
        logic [7:0] section_byte;
        logic       section_start;
    } t_pse_item;

    typedef struct packed {
        logic [12:0] vid_pid;
        logic        video_found;
        logic [12:0] aud_pid;
        logic        audio_found;
        logic        teletext_present;
        logic [11:0] section_size;
        logic        malformed;
    } t_pse_result;

endpackage

`default_nettype wire

// ===== src/pmt_stream_pid_extractor_core.sv =====
// result path: the last section byte passes the input register and the parse step into the result register
// throughput: one section byte per cycle, sustained, with the output not stalled
// set by the single parse step between the input register and the result register
// reset: i_rst_n synchronous, active low; parser waits for a section start,
// both pipeline registers empty
`default_nettype none

module pmt_stream_pid_extractor_core
    import pse_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // section byte channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_section_byte,
    input  wire logic        i_section_start,

    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [12:0]      o_vid_pid,
    output logic             o_video_found,
    output logic [12:0]      o_aud_pid,
    output logic             o_audio_found,
    output logic             o_teletext_present,
    output logic [11:0]      o_section_size,
    output logic             o_malformed
);

    t_pse_item   in_item;
    t_pse_item   held_item;
    logic        held_valid;
    logic        out_free;
    logic        step;
    logic        emit;
    t_pse_result step_result;
    t_pse_result out_result;

    assign in_item.section_byte  = i_section_byte;
    assign in_item.section_start = i_section_start;

    // a held byte is parsed only when the result slot can absorb a possible result,
    // so parser state and the result register always advance together
    assign step = held_valid && out_free;

    // input register: decouples the byte channel from the result side
    pse_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .i_take  (step),
        .o_stall (o_in_stall),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    // section parser: length capture, program info skip, es loop walk
    pse_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (held_item),
        .o_emit   (emit),
        .o_result (step_result)
    );

    // result register: holds a result until its transfer completes
    pse_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && emit),
        .i_result (step_result),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_vid_pid          = out_result.vid_pid;
    assign o_video_found      = out_result.video_found;
    assign o_aud_pid          = out_result.aud_pid;
    assign o_audio_found      = out_result.audio_found;
    assign o_teletext_present = out_result.teletext_present;
    assign o_section_size     = out_result.section_size;
    assign o_malformed        = out_result.malformed;

endmodule

`default_nettype wire

// ===== src/pse_in_reg.sv =====
`default_nettype none

module pse_in_reg
    import pse_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_pse_item i_item,
    input  wire logic      i_take,
    output logic           o_stall,
    output logic           o_valid,
    output t_pse_item      o_item
);

    logic      r_valid;
    t_pse_item r_item;
    logic      load;

    // hold while the parser cannot take the current byte
    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== src/pse_parser.sv =====
`default_nettype none

module pse_parser
    import pse_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_pse_item i_item,
    output logic           o_emit,
    output t_pse_result    o_result
);

    logic [11:0] r_pos,       n_pos;
    logic        r_active,    n_active;
    logic [11:0] r_len,       n_len;
    logic [11:0] r_skip,      n_skip;
    logic [2:0]  r_phase,     n_phase;
    logic [7:0]  r_type,      n_type;
    logic [4:0]  r_pid_hi,    n_pid_hi;
    logic [12:0] r_vid_pid,   n_vid_pid;
    logic        r_video_fnd, n_video_fnd;
    logic [12:0] r_aud_pid,   n_aud_pid;
    logic        r_audio_fnd, n_audio_fnd;
    logic        r_ttx,       n_ttx;
    logic        r_bad,       n_bad;

    logic [7:0]  b;
    logic [11:0] len_full;
    logic [11:0] skip_full;
    logic [11:0] skip_dec;
    logic [11:0] loop_end;
    logic [12:0] pos_inc;
    logic [12:0] pid;

    always_comb begin
        b         = i_item.section_byte;
        len_full  = r_len | {4'd0, b};
        skip_full = r_skip | {4'd0, b};
        skip_dec  = r_skip - 12'd1;
        loop_end  = r_len - CRC_BYTES;
        pos_inc   = {1'b0, r_pos} + 13'd1;
        pid       = {r_pid_hi, b};

        n_pos       = r_pos;
        n_active    = r_active;
        n_len       = r_len;
        n_skip      = r_skip;
        n_phase     = r_phase;
        n_type      = r_type;
        n_pid_hi    = r_pid_hi;
        n_vid_pid   = r_vid_pid;
        n_video_fnd = r_video_fnd;
        n_aud_pid   = r_aud_pid;
        n_audio_fnd = r_audio_fnd;
        n_ttx       = r_ttx;
        n_bad       = r_bad;
        o_emit      = 1'b0;

        if (i_item.section_start) begin
            // fresh section, drop anything unfinished
            n_pos       = '0;
            n_active    = 1'b1;
            n_len       = '0;
            n_skip      = '0;
            n_phase     = PH_LENGTH;
            n_type      = '0;
            n_pid_hi    = '0;
            n_vid_pid   = '0;
            n_video_fnd = 1'b0;
            n_aud_pid   = '0;
            n_audio_fnd = 1'b0;
            n_ttx       = 1'b0;
            n_bad       = 1'b0;
        end else if (r_active) begin
            if (r_phase == PH_LENGTH) begin
                if (r_pos == 12'd0) begin
                    n_len = {b[3:0], 8'd0};
                    n_pos = 12'd1;
                end else begin
                    n_len = len_full;
                    if (len_full < MIN_LENGTH) begin
                        n_bad = 1'b1;
                    end
                    if (len_full == 12'd0) begin
                        o_emit   = 1'b1;
                        n_active = 1'b0;
                    end else begin
                        n_pos   = '0;
                        n_phase = PH_HEADER;
                    end
                end
            end else begin
                if (r_len >= MIN_LENGTH) begin
                    if (r_pos < loop_end) begin
                        unique case (r_phase)
                            PH_HEADER: begin
                                if (r_pos == OFF_INFO_HI) begin
                                    n_skip = {b[3:0], 8'd0};
                                end else if (r_pos == OFF_INFO_LO) begin
                                    n_skip  = skip_full;
                                    n_phase = (skip_full != 12'd0) ? PH_SKIP : PH_TYPE;
                                end
                            end
                            PH_SKIP: begin
                                n_skip = skip_dec;
                                if (skip_dec == 12'd0) begin
                                    n_phase = PH_TYPE;
                                end
                            end
                            PH_TYPE: begin
                                n_type = b;
                                if (b == ST_TTX) begin
                                    n_ttx = 1'b1;
                                end
                                n_phase = PH_PIDHI;
                            end
                            PH_PIDHI: begin
                                n_pid_hi = b[4:0];
                                n_phase  = PH_PIDLO;
                            end
                            PH_PIDLO: begin
                                if ((r_type == ST_VIDEO_A || r_type == ST_VIDEO_B)
                                        && !r_video_fnd) begin
                                    n_vid_pid   = pid;
                                    n_video_fnd = 1'b1;
                                end
                                if ((r_type == ST_AUDIO_A || r_type == ST_AUDIO_B)
                                        && !r_audio_fnd) begin
                                    n_aud_pid   = pid;
                                    n_audio_fnd = 1'b1;
                                end
                                n_phase = PH_INFOHI;
                            end
                            PH_INFOHI: begin
                                n_skip  = {b[3:0], 8'd0};
                                n_phase = PH_INFOLO;
                            end
                            default: begin
                                n_skip  = skip_full;
                                n_phase = (skip_full != 12'd0) ? PH_SKIP : PH_TYPE;
                            end
                        endcase
                    end else if (r_pos == loop_end && r_phase != PH_TYPE) begin
                        // entry or descriptors ran into the crc
                        n_bad = 1'b1;
                    end
                end
                if (pos_inc >= {1'b0, r_len}) begin
                    o_emit   = 1'b1;
                    n_active = 1'b0;
                end else begin
                    n_pos = pos_inc[11:0];
                end
            end
        end

        o_result.vid_pid          = n_vid_pid;
        o_result.video_found      = n_video_fnd;
        o_result.aud_pid          = n_aud_pid;
        o_result.audio_found      = n_audio_fnd;
        o_result.teletext_present = n_ttx;
        o_result.section_size     = n_len;
        o_result.malformed        = n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_active    <= 1'b0;
            r_len       <= '0;
            r_skip      <= '0;
            r_phase     <= PH_LENGTH;
            r_type      <= '0;
            r_pid_hi    <= '0;
            r_vid_pid   <= '0;
            r_video_fnd <= 1'b0;
            r_aud_pid   <= '0;
            r_audio_fnd <= 1'b0;
            r_ttx       <= 1'b0;
            r_bad       <= 1'b0;
        end else if (i_step) begin
            r_pos       <= n_pos;
            r_active    <= n_active;
            r_len       <= n_len;
            r_skip      <= n_skip;
            r_phase     <= n_phase;
            r_type      <= n_type;
            r_pid_hi    <= n_pid_hi;
            r_vid_pid   <= n_vid_pid;
            r_video_fnd <= n_video_fnd;
            r_aud_pid   <= n_aud_pid;
            r_audio_fnd <= n_audio_fnd;
            r_ttx       <= n_ttx;
            r_bad       <= n_bad;
        end
    end

endmodule

`default_nettype wire

// ===== src/pse_out_reg.sv =====
`default_nettype none

module pse_out_reg
    import pse_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire t_pse_result i_result,
    input  wire logic        i_stall,
    output logic             o_free,
    output logic             o_valid,
    output t_pse_result      o_result
);

    logic        r_valid;
    t_pse_result r_result;

    // slot can take a new result when empty or being drained this cycle
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== dv/pse_tb_pkg.sv =====
package pse_tb_pkg;

    import pse_pkg::*;

    class pmt_scoreboard;

        t_pse_result pending_results[$];
        int          errors;
        int          results_made;
        int          results_seen;

        // shadow copy of the section parser
        logic        active;
        logic [11:0] byte_pos;
        logic [11:0] sect_len;
        logic [11:0] skip_left;
        logic [2:0]  phase;
        logic [7:0]  stream_type;
        logic [4:0]  pid_hi;
        logic [13:0] video_held;
        logic [13:0] audio_held;
        logic        ttx_seen;
        logic        bad_seen;

        function new();
            errors       = 0;
            results_made = 0;
            results_seen = 0;
            active       = 1'b0;
            clear_section();
        endfunction

        function void clear_section();
            byte_pos    = '0;
            sect_len    = '0;
            skip_left   = '0;
            phase       = PH_LENGTH;
            stream_type = '0;
            pid_hi      = '0;
            video_held  = '0;
            audio_held  = '0;
            ttx_seen    = 1'b0;
            bad_seen    = 1'b0;
        endfunction

        function void close_section();
            t_pse_result r;
            r.vid_pid          = video_held[12:0];
            r.video_found      = video_held[13];
            r.aud_pid          = audio_held[12:0];
            r.audio_found      = audio_held[13];
            r.teletext_present = ttx_seen;
            r.section_size     = sect_len;
            r.malformed        = bad_seen;
            pending_results.push_back(r);
            results_made++;
            active = 1'b0;
        endfunction

        // one byte inside the header tail or the stream loop
        function void walk_loop(logic [7:0] b, logic [11:0] off);
            logic [12:0] pid;
            case (phase)
                PH_HEADER: begin
                    if (off == OFF_INFO_HI) begin
                        skip_left = {b[3:0], 8'h00};
                    end else if (off == OFF_INFO_LO) begin
                        skip_left = skip_left | {4'h0, b};
                        phase = (skip_left != '0) ? PH_SKIP : PH_TYPE;
                    end
                end
                PH_SKIP: begin
                    skip_left = skip_left - 12'd1;
                    if (skip_left == '0) phase = PH_TYPE;
                end
                PH_TYPE: begin
                    stream_type = b;
                    if (b == ST_TTX) ttx_seen = 1'b1;
                    phase = PH_PIDHI;
                end
                PH_PIDHI: begin
                    pid_hi = b[4:0];
                    phase  = PH_PIDLO;
                end
                PH_PIDLO: begin
                    pid = {pid_hi, b};
                    if ((stream_type == ST_VIDEO_A || stream_type == ST_VIDEO_B) &&
                        !video_held[13]) video_held = {1'b1, pid};
                    if ((stream_type == ST_AUDIO_A || stream_type == ST_AUDIO_B) &&
                        !audio_held[13]) audio_held = {1'b1, pid};
                    phase = PH_INFOHI;
                end
                PH_INFOHI: begin
                    skip_left = {b[3:0], 8'h00};
                    phase     = PH_INFOLO;
                end
                PH_INFOLO: begin
                    skip_left = skip_left | {4'h0, b};
                    phase = (skip_left != '0) ? PH_SKIP : PH_TYPE;
                end
                default: ;
            endcase
        endfunction

        // returns 1 when the byte is taken by the parser, 0 when ignored
        function bit note_byte(logic [7:0] b, logic s);
            logic [11:0] off;
            if (s) begin
                clear_section();
                active = 1'b1;
                return 1'b1;
            end
            if (!active) return 1'b0;
            if (phase == PH_LENGTH) begin
                if (byte_pos == '0) begin
                    sect_len = {b[3:0], 8'h00};
                    byte_pos = 12'd1;
                    return 1'b1;
                end
                sect_len = sect_len | {4'h0, b};
                if (sect_len < MIN_LENGTH) bad_seen = 1'b1;
                if (sect_len == '0) begin
                    close_section();
                    return 1'b1;
                end
                byte_pos = '0;
                phase    = PH_HEADER;
                return 1'b1;
            end
            off = byte_pos;
            if (sect_len >= MIN_LENGTH) begin
                if (off < sect_len - CRC_BYTES) walk_loop(b, off);
                else if (off == sect_len - CRC_BYTES && phase != PH_TYPE) bad_seen = 1'b1;
            end
            if ({1'b0, off} + 13'd1 >= {1'b0, sect_len}) close_section();
            else byte_pos = off + 12'd1;
            return 1'b1;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("result %0d: %s is %0h, predicted %0h",
                                 results_seen, name, got, want));
        endtask

        task check_result(t_pse_result got);
            t_pse_result want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report($sformatf("result %0d arrived with no section outstanding",
                                 results_seen));
                return;
            end
            want = pending_results.pop_front();
            check_field("vid_pid", 16'(got.vid_pid), 16'(want.vid_pid));
            check_field("video_found", 16'(got.video_found), 16'(want.video_found));
            check_field("aud_pid", 16'(got.aud_pid), 16'(want.aud_pid));
            check_field("audio_found", 16'(got.audio_found), 16'(want.audio_found));
            check_field("teletext_present", 16'(got.teletext_present),
                        16'(want.teletext_present));
            check_field("section_size", 16'(got.section_size), 16'(want.section_size));
            check_field("malformed", 16'(got.malformed), 16'(want.malformed));
        endtask

        function int outstanding();
            return pending_results.size();
        endfunction

    endclass

endpackage

// ===== dv/tb.sv =====
module tb;

    import pse_pkg::*;
    import pse_tb_pkg::*;

    localparam int FEED_ITEMS   = 1000;    // parsed bytes in the random part
    localparam int HOLD_START   = 400;     // parsed bytes before the long hold
    localparam int HOLD_CYCLES  = 400;     // length of the long receiver hold
    localparam int DRAIN_CYCLES = 8;       // settling time after the last result is checked
    localparam int CYCLE_LIMIT  = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_section_byte;
    logic        i_section_start;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [12:0] o_vid_pid;
    logic        o_video_found;
    logic [12:0] o_aud_pid;
    logic        o_audio_found;
    logic        o_teletext_present;
    logic [11:0] o_section_size;
    logic        o_malformed;

    pmt_stream_pid_extractor_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_section_byte     (i_section_byte),
        .i_section_start    (i_section_start),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_vid_pid          (o_vid_pid),
        .o_video_found      (o_video_found),
        .o_aud_pid          (o_aud_pid),
        .o_audio_found      (o_audio_found),
        .o_teletext_present (o_teletext_present),
        .o_section_size     (o_section_size),
        .o_malformed        (o_malformed)
    );

    pmt_scoreboard sb = new();

    bit calm;          // final stretch: neither side idles
    bit pressure_go;   // asks the receiver for its long hold
    int fed;           // bytes taken by the parser, ignored bytes not counted

    // clock, period of two units
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    // one byte transfer, with an optional idle burst in front of it
    // stall is sampled at the falling edge, where it is settled for the coming edge
    task automatic push_byte(input logic [7:0] b, input logic s);
        logic stalled;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_section_byte  <= b;
        i_section_start <= s;
        do begin
            @(negedge i_clk);
            stalled = (o_in_stall !== 1'b0);
            @(posedge i_clk);
        end while (stalled);
        if (sb.note_byte(b, s)) fed++;
    endtask

    // table id with the start flag, then the bytes that follow it
    task automatic send_pmt(input logic [7:0] sec[$]);
        push_byte(8'($urandom), 1'b1);
        foreach (sec[i]) push_byte(sec[i], 1'b0);
    endtask

    // writes the section length into bytes 1 and 2, pads with random bytes
    // so that at least the declared length is present
    function automatic void set_length(ref logic [7:0] sec[$], input int len);
        sec[0] = {sec[0][7:4], 4'(len >> 8)};
        sec[1] = 8'(len);
        while (sec.size() < len + 2) sec.push_back(8'($urandom));
    endfunction

    // a sound program map section, less its table id
    function automatic void make_pmt(output logic [7:0] sec[$], input int info_len,
                                     input int entries, input int max_es);
        int          es_len;
        logic [12:0] pid;
        logic [7:0]  st;
        sec = {};
        sec.push_back(8'($urandom));
        sec.push_back(8'($urandom));
        // program number, version, section numbers, pcr pid
        repeat (7) sec.push_back(8'($urandom));
        sec.push_back({4'($urandom_range(0, 15)), 4'(info_len >> 8)});
        sec.push_back(8'(info_len));
        repeat (info_len) sec.push_back(8'($urandom));
        repeat (entries) begin
            case ($urandom_range(0, 6))
                0:       st = ST_VIDEO_A;
                1:       st = ST_VIDEO_B;
                2:       st = ST_AUDIO_A;
                3:       st = ST_AUDIO_B;
                4:       st = ST_TTX;
                default: st = 8'($urandom);
            endcase
            pid    = 13'($urandom);
            es_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, max_es);
            sec.push_back(st);
            sec.push_back({3'($urandom_range(0, 7)), pid[12:8]});
            sec.push_back(pid[7:0]);
            sec.push_back({4'($urandom_range(0, 15)), 4'(es_len >> 8)});
            sec.push_back(8'(es_len));
            repeat (es_len) sec.push_back(8'($urandom));
        end
        // crc, never checked
        repeat (4) sec.push_back(8'($urandom));
        set_length(sec, sec.size() - 2);
    endfunction

    // receiver: random stall bursts, clean stretches, one long hold
    initial begin
        bit hold_done;
        bit stall_val;
        int n;
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (pressure_go && !hold_done) begin
                // long hold so the pipeline fills and the input backs up
                stall_val = 1'b1;
                n         = HOLD_CYCLES;
                hold_done = 1'b1;
            end else if (calm) begin
                stall_val = 1'b0;
                n         = 1;
            end else if ($urandom_range(0, 9) == 0) begin
                stall_val = 1'b0;
                n         = 64;
            end else begin
                stall_val = ($urandom_range(0, 2) == 0);
                n         = $urandom_range(1, 16);
            end
            i_out_stall <= stall_val;
            repeat (n) @(posedge i_clk);
        end
    end

    // result monitor: a transfer takes place at the rising edge after this sample
    initial begin
        t_pse_result got;
        forever begin
            @(negedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                got.vid_pid          = o_vid_pid;
                got.video_found      = o_video_found;
                got.aud_pid          = o_aud_pid;
                got.audio_found      = o_audio_found;
                got.teletext_present = o_teletext_present;
                got.section_size     = o_section_size;
                got.malformed        = o_malformed;
                sb.check_result(got);
            end
        end
    end

    // stimulus
    initial begin
        logic [7:0] sec[$];
        int         kind;
        int         len;
        int         delta;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_section_byte  <= 8'h00;
        i_section_start <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: a stray byte while waiting, a section abandoned after its
        // first length byte, a zero length section, then the shortest sound one
        push_byte(8'hFF, 1'b0);
        push_byte(8'h02, 1'b1);
        push_byte(8'h0F, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h00, 1'b0);
        make_pmt(sec, 0, 0, 0);
        send_pmt(sec);

        // random: mostly sound sections, the rest damaged or noise
        while (fed < FEED_ITEMS) begin
            if (fed >= HOLD_START) pressure_go = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                make_pmt(sec, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0,
                         $urandom_range(0, 6), 6);
                send_pmt(sec);
            end else if (kind < 72) begin
                // declared length off by a few bytes: overruns and junk entries
                make_pmt(sec, $urandom_range(0, 4), $urandom_range(0, 5), 6);
                delta = int'($urandom_range(0, 12)) - 6;
                len   = sec.size() - 2 + delta;
                if (len < 0) len = 0;
                set_length(sec, len);
                send_pmt(sec);
            end else if (kind < 80) begin
                // too short to hold a header
                sec = {8'($urandom), 8'($urandom)};
                set_length(sec, $urandom_range(0, 12));
                send_pmt(sec);
            end else if (kind < 88) begin
                // cut short, the next start drops it
                make_pmt(sec, $urandom_range(0, 4), $urandom_range(0, 5), 6);
                sec = sec[0:$urandom_range(0, sec.size() - 2)];
                send_pmt(sec);
            end else if (kind < 94) begin
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'b0);
            end else begin
                // random body, any descriptor lengths
                sec = {8'($urandom), 8'($urandom)};
                set_length(sec, $urandom_range(13, 40));
                send_pmt(sec);
            end
        end

        // final stretch without idling: a long program info run with a
        // non-zero high length nibble ahead of two entries, then a few ordinary ones
        calm = 1'b1;
        make_pmt(sec, 300, 2, 0);
        send_pmt(sec);
        repeat (8) begin
            make_pmt(sec, $urandom_range(0, 3), $urandom_range(1, 5), 4);
            send_pmt(sec);
        end
        i_in_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/pse_pkg.sv
src/pse_in_reg.sv
src/pse_parser.sv
src/pse_out_reg.sv
src/pmt_stream_pid_extractor_core.sv
dv/pse_tb_pkg.sv
dv/tb.sv
